// ===== rtl/pma_pkg.sv =====
// Shared types and constants of the page mapping allocator.
package pma_pkg;

	localparam int unsigned DIR_ENTRIES = 1024;
	localparam int unsigned DIR_IDX_W   = 10;
	localparam int unsigned SIZE_W      = 17;
	localparam logic [31:0] PAGE_BYTES  = 32'd4096;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [31:0] ENTRY_FLAGS = 32'h0000_0003;

	typedef enum logic [1:0] {
		ACT_MAP   = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_HEAP  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_DIR   = 2'd0,
		KIND_TABLE = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_UNALIGNED = 3'd1,
		ERR_FRAMES    = 3'd2,
		ERR_TABLES    = 3'd3,
		ERR_HEAP_FULL = 3'd4,
		ERR_TOO_LARGE = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		CFG_FRAME_BASE  = 3'd0,
		CFG_FRAME_WORDS = 3'd1,
		CFG_TABLE_START = 3'd2,
		CFG_TABLE_END   = 3'd3,
		CFG_HEAP_START  = 3'd4,
		CFG_HEAP_END    = 3'd5,
		CFG_DIR_BASE    = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_FAIL  = 2'd0,
		OP_MAP   = 2'd1,
		OP_ALLOC = 2'd2,
		OP_HEAP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAP,
		ST_READ,
		ST_CHECK,
		ST_DIR,
		ST_TABLE,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		err_t              err;
		logic [31:0]       va;
		logic [31:0]       pa;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] waddr;
		logic [31:0] wdata;
		logic [31:0] raddr;
		err_t        err;
		logic        last;
	} result_t;

endpackage

// ===== rtl/page_mapping_allocator.sv =====
// A request refused outright goes straight to its done item. A map or frame request reads the
// directory, writes a directory entry if none is present and then a table entry; a heap request
// does so for each page (at most MAX_REQUEST_BYTES / 4096 + 1 pages). A full result queue stalls.
// The sequencer takes one request at a time, the next one only after a done item.
// Reset is asynchronous and active low; the directory is then cleared, with full held high.
// Top level of the page mapping allocator.
module page_mapping_allocator import pma_pkg::*; #(
	parameter int unsigned BITMAP_WORDS      = 2048,
	parameter int unsigned MAX_REQUEST_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [31:0] size_bytes,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic [31:0] result_address,
	output logic [2:0]  error,
	output logic        last
);

	// The front stage classifies requests and holds up to two of them, so a
	// new transfer can be taken while the sequencer is still working.
	cmd_t    cmd;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    front_full;
	logic    clearing;
	logic    res_push;
	logic    res_full;
	result_t res_in;
	result_t res_out;

	// No request is taken while the directory clearing pass runs.
	assign full = front_full || clearing;

	pma_front #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push && !clearing),
		.full      (front_full),
		.action    (action),
		.virt_addr (virt_addr),
		.phys_addr (phys_addr),
		.size_bytes(size_bytes),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop)
	);

	// The sequencer looks up the directory, takes frames and tables from
	// their pools and produces the write and done items in order.
	pma_back #(
		.BITMAP_WORDS     (BITMAP_WORDS),
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full),
		.clearing (clearing)
	);

	// The result queue decouples the sequencer from a stalled consumer.
	pma_fifo #(.T(result_t), .DEPTH(4)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign kind           = res_out.kind;
	assign write_address  = res_out.waddr;
	assign write_data     = res_out.wdata;
	assign result_address = res_out.raddr;
	assign error          = res_out.err;
	assign last           = res_out.last;

`ifndef ASSERT_OFF
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full) else $error("request taken during clearing pass");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into full queue");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (kind == KIND_DONE))) else $error("last flag mismatch");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error != ERR_OK) |-> (result_address == 32'd0))
		else $error("failed request returned an address");
`endif

endmodule

// ===== rtl/pma_fifo.sv =====
// Small first-in first-out queue used between the allocator stages.
module pma_fifo import pma_pkg::*; #(
	parameter type T = logic,
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	T              mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/pma_front.sv =====
// Request intake: classifies each request and queues it for the sequencer.
module pma_front import pma_pkg::*; #(
	parameter int unsigned MAX_REQUEST_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [31:0] size_bytes,
	output cmd_t        cmd,
	output logic        cmd_empty,
	input  logic        cmd_pop
);

	cmd_t cls;

	// Checks that need no stored state are settled here.
	always_comb begin
		cls.op   = OP_FAIL;
		cls.err  = ERR_OK;
		cls.va   = virt_addr;
		cls.pa   = phys_addr;
		cls.size = size_bytes[SIZE_W-1:0];
		case (action)
			ACT_MAP: begin
				cls.op = OP_MAP;
			end
			ACT_ALLOC: begin
				if (virt_addr[11:0] != 12'd0) begin
					cls.err = ERR_UNALIGNED;
				end else begin
					cls.op = OP_ALLOC;
				end
			end
			ACT_HEAP: begin
				if (size_bytes > 32'(MAX_REQUEST_BYTES)) begin
					cls.err = ERR_TOO_LARGE;
				end else begin
					cls.op = OP_HEAP;
				end
			end
			default: begin
				cls.op = OP_FAIL;
			end
		endcase
	end

	pma_fifo #(.T(cmd_t), .DEPTH(2)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

// ===== rtl/pma_back.sv =====
// Request sequencer: directory memory, frame and table pools, heap pointers.
module pma_back import pma_pkg::*; #(
	parameter int unsigned BITMAP_WORDS      = 2048,
	parameter int unsigned MAX_REQUEST_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  cmd_t        cmd,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	output logic        res_push,
	output result_t     res,
	input  logic        res_full,
	output logic        clearing
);

	localparam int unsigned PW        = $clog2(BITMAP_WORDS + 1);
	localparam int unsigned MAX_PAGES = MAX_REQUEST_BYTES / 4096 + 1;
	localparam int unsigned PGW       = $clog2(MAX_PAGES + 1);

	state_t state_q, state_d;

	logic [31:0] frame_base_q, tbl_end_q, heap_end_q, dir_base_q;
	logic [11:0] frame_words_q;
	logic [31:0] next_tbl_q, heap_cur_q, heap_map_q;

	// Frames are taken lowest first and never freed, so every word below
	// the pointer is full and every word above it is empty. The word at the
	// pointer holds a run of cnt_q low ones.
	logic [PW-1:0] ptr_q;
	logic [5:0]    cnt_q;

	logic [31:0]          va_q, pa_q, ret_q, entry_q;
	err_t                 err_q;
	logic [32:0]          target_q;
	logic [PGW-1:0]       pages_q;
	logic                 heap_q, alloc_q;
	logic [DIR_IDX_W-1:0] clr_q;

	logic [31:0]          dir_mem [DIR_ENTRIES];
	logic [31:0]          dir_rdata_q;
	logic                 dir_we;
	logic [DIR_IDX_W-1:0] dir_waddr;
	logic [31:0]          dir_wdata;

	logic [31:0] limit;
	logic        frames_out;
	logic [31:0] frame_pa;
	logic [32:0] heap_tgt;
	logic        heap_over;
	logic        present;
	logic        tables_out;
	logic        more_pages;
	logic        heap_unaligned;

	assign limit      = (32'(frame_words_q) > 32'(BITMAP_WORDS)) ?
	                    32'(BITMAP_WORDS) : 32'(frame_words_q);
	assign frames_out = (32'(ptr_q) >= limit);
	assign frame_pa   = frame_base_q + (32'({ptr_q, cnt_q[4:0]}) << 12);
	assign heap_tgt   = {1'b0, heap_cur_q} + 33'(cmd.size);
	assign heap_over  = (heap_tgt > {1'b0, heap_end_q});
	assign present    = dir_rdata_q[0];
	assign tables_out = !present && (next_tbl_q >= tbl_end_q);
	assign more_pages = (target_q > {1'b0, heap_map_q}) && (pages_q < PGW'(MAX_PAGES));
	// A heap page that does not start on a page boundary fails like any frame request.
	assign heap_unaligned = more_pages && (heap_map_q[11:0] != 12'd0);
	assign clearing   = (state_q == ST_CLEAR);

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rdata_q <= dir_mem[va_q[31:22]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '{kind: KIND_DONE, waddr: '0, wdata: '0, raddr: '0,
		              err: ERR_OK, last: 1'b0};
		dir_we    = 1'b0;
		dir_waddr = va_q[31:22];
		dir_wdata = next_tbl_q | ENTRY_FLAGS;
		case (state_q)
			ST_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = clr_q;
				dir_wdata = '0;
				if (clr_q == DIR_IDX_W'(DIR_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_MAP, OP_ALLOC: state_d = ST_READ;
						OP_HEAP:          state_d = heap_over ? ST_DONE : ST_HEAP;
						default:          state_d = ST_DONE;
					endcase
				end
			end
			ST_HEAP: begin
				state_d = (more_pages && !heap_unaligned) ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				state_d = (alloc_q && frames_out) ? ST_DONE : ST_CHECK;
			end
			ST_CHECK: begin
				if (tables_out) begin
					state_d = ST_DONE;
				end else if (!present) begin
					dir_we  = 1'b1;
					state_d = ST_DIR;
				end else begin
					state_d = ST_TABLE;
				end
			end
			ST_DIR: begin
				res.kind  = KIND_DIR;
				res.waddr = dir_base_q + {20'd0, va_q[31:22], 2'b00};
				res.wdata = entry_q;
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_TABLE;
				end
			end
			ST_TABLE: begin
				res.kind  = KIND_TABLE;
				res.waddr = {entry_q[31:12], va_q[21:12], 2'b00};
				res.wdata = pa_q | ENTRY_FLAGS;
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = heap_q ? ST_HEAP : ST_DONE;
				end
			end
			ST_DONE: begin
				res.kind  = KIND_DONE;
				res.raddr = (err_q == ERR_OK) ? ret_q : '0;
				res.err   = err_q;
				res.last  = 1'b1;
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers and the long-lived pool state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= 32'd9437184;
			frame_words_q <= 12'd1848;
			tbl_end_q     <= 32'd83886080;
			heap_end_q    <= 32'd285212672;
			dir_base_q    <= 32'd0;
			next_tbl_q    <= 32'd5242880;
			heap_cur_q    <= 32'd251658240;
			heap_map_q    <= 32'd251658240;
			ptr_q         <= '0;
			cnt_q         <= '0;
			clr_q         <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + DIR_IDX_W'(1);
			end
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FRAME_BASE:  frame_base_q <= cfg_data;
					CFG_FRAME_WORDS: frame_words_q <= cfg_data[11:0];
					CFG_TABLE_START: next_tbl_q <= cfg_data;
					CFG_TABLE_END:   tbl_end_q <= cfg_data;
					CFG_HEAP_START:  begin
						heap_cur_q <= cfg_data;
						heap_map_q <= cfg_data;
					end
					CFG_HEAP_END:    heap_end_q <= cfg_data;
					CFG_DIR_BASE:    dir_base_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CHECK && !tables_out) begin
				if (!present) begin
					next_tbl_q <= next_tbl_q + PAGE_BYTES;
				end
				if (alloc_q) begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						ptr_q <= ptr_q + PW'(1);
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
			end
			if (state_q == ST_TABLE && !res_full && heap_q) begin
				heap_map_q <= (heap_map_q > ALL_ONES - PAGE_BYTES) ?
				              ALL_ONES : heap_map_q + PAGE_BYTES;
			end
			if (state_q == ST_HEAP && !more_pages) begin
				heap_cur_q <= target_q[31:0];
			end
		end
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					va_q     <= cmd.va;
					pa_q     <= cmd.pa;
					err_q    <= cmd.err;
					ret_q    <= cmd.va;
					alloc_q  <= (cmd.op == OP_ALLOC) || (cmd.op == OP_HEAP);
					heap_q   <= (cmd.op == OP_HEAP);
					target_q <= heap_tgt;
					pages_q  <= '0;
					if (cmd.op == OP_FAIL) begin
						ret_q <= '0;
					end
					if (cmd.op == OP_HEAP) begin
						ret_q <= heap_cur_q;
						if (heap_over) begin
							err_q <= ERR_HEAP_FULL;
						end
					end
				end
			end
			ST_HEAP: begin
				va_q <= heap_map_q;
				if (heap_unaligned) begin
					err_q <= ERR_UNALIGNED;
				end
			end
			ST_READ: begin
				if (alloc_q && frames_out) begin
					err_q <= ERR_FRAMES;
				end
			end
			ST_CHECK: begin
				if (tables_out) begin
					err_q <= ERR_TABLES;
				end else begin
					entry_q <= present ? dir_rdata_q : (next_tbl_q | ENTRY_FLAGS);
					if (alloc_q) begin
						pa_q <= frame_pa;
					end
				end
			end
			ST_TABLE: begin
				if (!res_full) begin
					pages_q <= pages_q + PGW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule
